// ----- rtl/wisel_pkg.sv -----
// ----------------------------------------------------------------------------
// wisel_pkg
// shared constants and types of the weighted interleave node selector
// ----------------------------------------------------------------------------
package wisel_pkg;

  localparam int NODES     = 4;
  localparam int STREAMS   = 64;
  localparam int CNT_W     = 32;
  localparam int WEIGHT_W  = 8;
  localparam int SUM_W     = WEIGHT_W + $clog2(NODES);
  localparam int NODE_W    = 2;
  localparam int SID_W     = 6;
  localparam int ADDR_W    = $clog2(STREAMS);
  localparam int CFG_IDX_W = 8;
  localparam int STEP_W    = $clog2(CNT_W);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_PICK,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/wisel_if.sv -----
// ----------------------------------------------------------------------------
// wisel_if
// valid/ready channels of the node selector: request, result, configuration
// ----------------------------------------------------------------------------
interface wisel_in_if;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [wisel_pkg::SID_W-1:0] stream_id;

  modport source (output valid, output op, output stream_id, input ready);
  modport sink   (input valid, input op, input stream_id, output ready);
endinterface

interface wisel_out_if;
  logic                         valid;
  logic                         ready;
  logic [wisel_pkg::NODE_W-1:0] node;
  logic                         error;

  modport source (output valid, output node, output error, input ready);
  modport sink   (input valid, input node, input error, output ready);
endinterface

interface wisel_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wisel_pkg::CFG_IDX_W-1:0] index;
  logic [wisel_pkg::WEIGHT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/wisel_mod.sv -----
// ----------------------------------------------------------------------------
// wisel_mod
// iterative remainder unit: one restoring step per cycle over the counter
// ----------------------------------------------------------------------------
module wisel_mod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wisel_pkg::CNT_W-1:0]    dividend,
  input  logic [wisel_pkg::SUM_W-1:0]    divisor,
  output logic                           done,
  output logic [wisel_pkg::SUM_W-1:0]    rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [wisel_pkg::STEP_W-1:0]  step_r;
  logic [wisel_pkg::CNT_W-1:0]   dvd_r;
  logic [wisel_pkg::SUM_W-1:0]   dvs_r;
  logic [wisel_pkg::SUM_W-1:0]   rem_r;
  logic [wisel_pkg::SUM_W:0]     trial;
  logic [wisel_pkg::SUM_W-1:0]   rem_nxt;
  logic                          last_step;

  assign trial     = {rem_r, dvd_r[wisel_pkg::CNT_W-1]};
  assign last_step = (step_r == wisel_pkg::STEP_W'(wisel_pkg::CNT_W - 1));

  always_comb begin
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = wisel_pkg::SUM_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[wisel_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[wisel_pkg::CNT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/weighted_interleave_node_select.sv -----
// ----------------------------------------------------------------------------
// weighted_interleave_node_select
// weighted interleave of page allocations over memory nodes, per stream
// ----------------------------------------------------------------------------
// in_ch takes one transaction at a time: op allocate bumps the stream's
// counter and gives one result on out_ch, op clear zeroes the counter and
// gives none. cfg_ch writes node weights (index 0..3, 8 bits), always ready;
// write only while the block is idle. out_ch carries node and error.
// Counters sit in a 64 x 32 synchronous RAM with one valid flop per stream.
// An allocate passes from acceptance to result through the RAM read at the
// accepting edge, one read-modify-write, the bit-serial remainder unit (32
// steps and its done flag), one node pick and one output load. The next
// transaction is taken only once the block is back in idle after the output
// load; the remainder unit sets the rate. A clear completes at its
// accepting edge and leaves the block idle. A zero weight sum skips the
// remainder unit and goes from the read-modify-write to the output load.
// A new transaction is taken while a result still waits in the output
// register; a stalled receiver holds the next result in its final state.
// After reset all counters read as zero and every weight is 1.
// ----------------------------------------------------------------------------
module weighted_interleave_node_select (
  input  logic        clk,
  input  logic        rst_n,
  wisel_in_if.sink    in_ch,
  wisel_out_if.source out_ch,
  wisel_cfg_if.sink   cfg_ch
);

  wisel_pkg::state_t                  state_r, state_nxt;
  logic [wisel_pkg::ADDR_W-1:0]       sid_r, sid_nxt;
  logic [wisel_pkg::NODE_W-1:0]       res_node_r, res_node_nxt;
  logic                               res_err_r, res_err_nxt;
  logic [wisel_pkg::STREAMS-1:0]      vld_r;
  logic [wisel_pkg::NODES-1:0][wisel_pkg::WEIGHT_W-1:0] weight_r;
  logic [wisel_pkg::CNT_W-1:0]        mem [wisel_pkg::STREAMS];
  logic [wisel_pkg::CNT_W-1:0]        rd_data_r;
  logic                               out_valid_r;
  logic [wisel_pkg::NODE_W-1:0]       out_node_r;
  logic                               out_error_r;

  logic [wisel_pkg::ADDR_W-1:0]       in_sid;
  logic                               rd_en;
  logic                               mem_we;
  logic                               vld_set;
  logic                               vld_clr;
  logic                               div_start;
  logic                               div_done;
  logic [wisel_pkg::SUM_W-1:0]        div_rem;
  logic                               out_load;
  logic [wisel_pkg::CNT_W-1:0]        cnt_cur;
  logic [wisel_pkg::CNT_W-1:0]        cnt_inc;
  logic [wisel_pkg::SUM_W-1:0]        wsum;
  logic [wisel_pkg::SUM_W-1:0]        run;
  logic                               found;
  logic [wisel_pkg::NODE_W-1:0]       pick_node;

  assign in_sid  = in_ch.stream_id[wisel_pkg::ADDR_W-1:0];
  assign cnt_cur = vld_r[sid_r] ? rd_data_r : '0;
  assign cnt_inc = cnt_cur + 1'b1;

  always_comb begin
    wsum = '0;
    for (int n = 0; n < wisel_pkg::NODES; n++) begin
      wsum = wsum + wisel_pkg::SUM_W'(weight_r[n]);
    end
  end

  // walk from the highest node down
  always_comb begin
    run       = '0;
    found     = 1'b0;
    pick_node = '0;
    for (int n = wisel_pkg::NODES - 1; n >= 0; n--) begin
      run = run + wisel_pkg::SUM_W'(weight_r[n]);
      if (!found && (div_rem < run)) begin
        pick_node = wisel_pkg::NODE_W'(n);
        found     = 1'b1;
      end
    end
  end

  wisel_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cnt_inc),
    .divisor  (wsum),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    sid_nxt      = sid_r;
    res_node_nxt = res_node_r;
    res_err_nxt  = res_err_r;
    in_ch.ready  = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    vld_set      = 1'b0;
    vld_clr      = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      wisel_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          sid_nxt = in_sid;
          if (in_ch.op == wisel_pkg::OP_CLEAR) begin
            vld_clr = 1'b1;
          end else begin
            rd_en     = 1'b1;
            state_nxt = wisel_pkg::ST_READ;
          end
        end
      end
      wisel_pkg::ST_READ: begin
        mem_we  = 1'b1;
        vld_set = 1'b1;
        if (wsum == '0) begin
          res_node_nxt = '0;
          res_err_nxt  = 1'b1;
          state_nxt    = wisel_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = wisel_pkg::ST_DIV;
        end
      end
      wisel_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = wisel_pkg::ST_PICK;
        end
      end
      wisel_pkg::ST_PICK: begin
        res_node_nxt = pick_node;
        res_err_nxt  = 1'b0;
        state_nxt    = wisel_pkg::ST_OUT;
      end
      wisel_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = wisel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wisel_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wisel_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sid_r      <= sid_nxt;
    res_node_r <= res_node_nxt;
    res_err_r  <= res_err_nxt;
  end

  // counter ram
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[in_sid];
    end
    if (mem_we) begin
      mem[sid_r] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (vld_clr) begin
      vld_r[in_sid] <= 1'b0;
    end else if (vld_set) begin
      vld_r[sid_r] <= 1'b1;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < wisel_pkg::NODES; n++) begin
        weight_r[n] <= wisel_pkg::WEIGHT_W'(1);
      end
    end else if (cfg_ch.valid &&
                 (cfg_ch.index < wisel_pkg::CFG_IDX_W'(wisel_pkg::NODES))) begin
      weight_r[cfg_ch.index[wisel_pkg::NODE_W-1:0]] <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node_r  <= res_node_r;
      out_error_r <= res_err_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.node  = out_node_r;
  assign out_ch.error = out_error_r;

endmodule

// ----- sim/weighted_interleave_node_select_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_interleave_node_select_tb
// drives allocate and clear transactions over several node weight settings,
// predicts every node pick from its own per-stream counters and weights, and
// checks each result in order while both channels idle and stall at random
// ----------------------------------------------------------------------------
module weighted_interleave_node_select_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam logic [wisel_pkg::SID_W-1:0] TOP_SID =
    wisel_pkg::SID_W'(wisel_pkg::STREAMS - 1);

  typedef struct packed {
    logic [wisel_pkg::NODE_W-1:0] node;
    logic                         error;
  } pick_t;

  class node_pick_scoreboard;
    logic [wisel_pkg::WEIGHT_W-1:0] weight [wisel_pkg::NODES];
    logic [wisel_pkg::CNT_W-1:0]    stream_cnt [wisel_pkg::STREAMS];
    pick_t                          expected_picks [$];
    int                             mismatches;

    function new();
      foreach (weight[i]) weight[i] = wisel_pkg::WEIGHT_W'(1);
      foreach (stream_cnt[i]) stream_cnt[i] = '0;
      mismatches = 0;
    endfunction

    function void write_weight(int unsigned idx, logic [wisel_pkg::WEIGHT_W-1:0] val);
      if (idx < wisel_pkg::NODES) weight[idx] = val;
    endfunction

    function void note_request(logic op, logic [wisel_pkg::SID_W-1:0] sid);
      int unsigned slot;
      int unsigned total;
      int unsigned rem;
      int unsigned run;
      int          n;
      pick_t       pick;
      slot = sid % wisel_pkg::STREAMS;
      if (op == wisel_pkg::OP_CLEAR) begin
        stream_cnt[slot] = '0;
        return;
      end
      stream_cnt[slot] = stream_cnt[slot] + 1'b1;
      total = 0;
      foreach (weight[i]) total += weight[i];
      pick = '0;
      if (total == 0) begin
        pick.error = 1'b1;
      end else begin
        rem = stream_cnt[slot] % total;
        run = 0;
        for (n = wisel_pkg::NODES - 1; n >= 0; n--) begin
          run += weight[n];
          if (rem < run) begin
            pick.node = wisel_pkg::NODE_W'(n);
            break;
          end
        end
      end
      expected_picks.push_back(pick);
    endfunction

    function void check_pick(logic [wisel_pkg::NODE_W-1:0] node, logic err);
      pick_t want;
      if (expected_picks.size() == 0) begin
        $error("unexpected result: node %0d error %0d", node, err);
        mismatches++;
        return;
      end
      want = expected_picks.pop_front();
      if (node !== want.node) begin
        $error("node: expected %0d, actual %0d", want.node, node);
        mismatches++;
      end
      if (err !== want.error) begin
        $error("error: expected %0d, actual %0d", want.error, err);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet;
  int   gap_pct;
  int   stall_pct;
  int   stall_left = 0;
  logic [wisel_pkg::SID_W-1:0] hot_stream [4];
  node_pick_scoreboard pick_board;

  wisel_in_if  in_ch ();
  wisel_out_if out_ch ();
  wisel_cfg_if cfg_ch ();

  weighted_interleave_node_select uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) pick_board.write_weight(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) pick_board.note_request(in_ch.op, in_ch.stream_id);
      if (out_ch.valid && out_ch.ready) pick_board.check_pick(out_ch.node, out_ch.error);
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 14);
    end
    out_ch.ready <= (stall_left == 0);
  end

  task automatic push_request(input logic op, input logic [wisel_pkg::SID_W-1:0] sid);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.stream_id <= sid;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pick_board.expected_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [wisel_pkg::WEIGHT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= wisel_pkg::CFG_IDX_W'(idx);
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_weights(
    input logic [wisel_pkg::NODES-1:0][wisel_pkg::WEIGHT_W-1:0] w
  );
    int i;
    settle();
    for (i = 0; i < wisel_pkg::NODES; i++) write_reg(i, w[i]);
    // writes past the node registers are dropped
    if ($urandom_range(0, 1)) begin
      write_reg($urandom_range(wisel_pkg::NODES, 255),
                wisel_pkg::WEIGHT_W'($urandom_range(0, 255)));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int k;
    logic op;
    logic [wisel_pkg::SID_W-1:0] sid;
    for (k = 0; k < count; k++) begin
      op = ($urandom_range(0, 99) < 12) ? wisel_pkg::OP_CLEAR : wisel_pkg::OP_ALLOC;
      if (op == wisel_pkg::OP_ALLOC && $urandom_range(0, 1)) begin
        sid = hot_stream[$urandom_range(0, 3)];
      end else begin
        sid = wisel_pkg::SID_W'($urandom_range(0, wisel_pkg::STREAMS - 1));
      end
      push_request(op, sid);
    end
  endtask

  initial begin
    logic [wisel_pkg::NODES-1:0][wisel_pkg::WEIGHT_W-1:0] w;
    int ph;
    int i;
    pick_board = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = wisel_pkg::OP_ALLOC;
    in_ch.stream_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    quiet = 1'b0;
    gap_pct = 25;
    stall_pct = 15;
    foreach (hot_stream[j]) begin
      hot_stream[j] = wisel_pkg::SID_W'($urandom_range(0, wisel_pkg::STREAMS - 1));
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset weights, counter walk, clear and the top stream
    repeat (5) push_request(wisel_pkg::OP_ALLOC, '0);
    push_request(wisel_pkg::OP_CLEAR, '0);
    push_request(wisel_pkg::OP_ALLOC, '0);
    push_request(wisel_pkg::OP_ALLOC, TOP_SID);
    push_request(wisel_pkg::OP_CLEAR, TOP_SID);
    push_request(wisel_pkg::OP_ALLOC, TOP_SID);

    // zero weight sum
    load_weights('0);
    push_request(wisel_pkg::OP_ALLOC, 6'd21);
    push_request(wisel_pkg::OP_ALLOC, 6'd42);

    load_weights({8'd0, 8'd0, 8'd0, 8'd255});
    repeat (2) push_request(wisel_pkg::OP_ALLOC, '0);
    load_weights({8'd255, 8'd0, 8'd0, 8'd0});
    repeat (2) push_request(wisel_pkg::OP_ALLOC, '0);
    load_weights({wisel_pkg::NODES{8'd255}});
    push_request(wisel_pkg::OP_ALLOC, '0);
    push_request(wisel_pkg::OP_ALLOC, TOP_SID);

    // out-of-range register writes must leave the weights alone
    settle();
    write_reg(wisel_pkg::NODES, 8'd7);
    write_reg(255, 8'd0);
    cfg_ch.valid <= 1'b0;
    push_request(wisel_pkg::OP_ALLOC, '0);
    load_weights({8'd0, 8'd1, 8'd0, 8'd2});
    repeat (3) push_request(wisel_pkg::OP_ALLOC, '0);

    for (ph = 0; ph < 10; ph++) begin
      w = '0;
      case (ph % 5)
        0: begin
          for (i = 0; i < wisel_pkg::NODES; i++) begin
            w[i] = wisel_pkg::WEIGHT_W'($urandom_range(0, 255));
          end
        end
        1: begin
          for (i = 0; i < wisel_pkg::NODES; i++) begin
            w[i] = wisel_pkg::WEIGHT_W'($urandom_range(0, 3));
          end
        end
        2: begin
          for (i = 0; i < wisel_pkg::NODES; i++) w[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        3: begin
          w[$urandom_range(0, wisel_pkg::NODES - 1)] =
            wisel_pkg::WEIGHT_W'($urandom_range(0, 255));
        end
        default: begin
          for (i = 0; i < wisel_pkg::NODES; i++) begin
            w[i] = wisel_pkg::WEIGHT_W'($urandom_range(1, 255));
          end
        end
      endcase
      case (ph % 3)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 25;
          stall_pct = 15;
        end
        default: begin
          gap_pct = 60;
          stall_pct = 40;
        end
      endcase
      if (ph == 9) quiet = 1'b1;
      load_weights(w);
      random_phase(118);
    end

    settle();
    if (pick_board.mismatches == 0) begin
      $display("weighted_interleave_node_select_tb OK");
    end else begin
      $display("weighted_interleave_node_select_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("weighted_interleave_node_select_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/wisel_pkg.sv
rtl/wisel_if.sv
rtl/wisel_mod.sv
rtl/weighted_interleave_node_select.sv
sim/weighted_interleave_node_select_tb.sv
